// ===== rtl/lqst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqst_pkg
// shared types and constants of the link quality score tracker
// ----------------------------------------------------------------------------
package lqst_pkg;

  // fixed point widths
  localparam int FRAC_W     = 16;          // q0.16 fraction bits
  localparam int Q_W        = 17;          // q0.16 values up to and including 1.0
  localparam int SNR_W      = 16;          // signed q8.8
  localparam int SAMPLE_W   = 16;
  localparam int ACCUM_W    = 32;          // sample accumulator
  localparam int PERIOD_W   = 24;
  localparam int KIND_W     = 3;
  localparam int OPND_W     = 18;          // signed multiplier operands
  localparam int ACC_W      = 38;          // multiply accumulate register
  localparam int SNR_SPAN_W = 13;          // bits needed for the snr span

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 2'd1;

  // event kinds
  localparam logic [KIND_W-1:0] KIND_SAMPLES   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SNR       = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BER       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FRAME_OK  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FRAME_ERR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd5;

  // constants
  localparam logic [Q_W-1:0]        ONE_Q16      = 17'd65536;
  localparam logic [Q_W-1:0]        ALPHA_RESET  = 17'd6554;
  localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 24'd1024;
  localparam logic [Q_W-1:0]        SCORE_RESET  = 17'd32768;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 38'sd32768;

  // snr score: (snr + 10 dB) / 30 dB in q8.8
  localparam logic signed [SNR_W:0]   SNR_OFFSET = 17'sd2560;
  localparam logic [SNR_SPAN_W-1:0]   SNR_SPAN   = 13'd7680;
  localparam logic [FRAC_W-1:0]       SNR_ROUND  = 16'd3840;

  // ber and fer score slopes
  localparam logic [9:0] BER_GAIN = 10'd1000;
  localparam logic [3:0] FER_GAIN = 4'd10;

  // score weights 0.5, 0.3, 0.2 in q0.16
  localparam logic signed [OPND_W-1:0] W_SNR = 18'sd32768;
  localparam logic signed [OPND_W-1:0] W_BER = 18'sd19661;
  localparam logic signed [OPND_W-1:0] W_FER = 18'sd13107;

  // command to the multiply accumulate unit
  typedef struct packed {
    logic en;    // take a product this cycle
    logic clr;   // restart from the rounding constant
  } mac_cmd_t;

endpackage

// ===== rtl/lqst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqst channel interfaces
// event input, result output and configuration write channels
// ----------------------------------------------------------------------------
interface lqst_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [lqst_pkg::KIND_W-1:0]            kind;
  logic [lqst_pkg::SAMPLE_W-1:0]          sample_count;
  logic signed [lqst_pkg::SNR_W-1:0]      snr_report;
  logic [lqst_pkg::Q_W-1:0]               ber_report;

  modport source (output valid, kind, sample_count, snr_report, ber_report, input ready);
  modport sink   (input valid, kind, sample_count, snr_report, ber_report, output ready);
endinterface

interface lqst_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [lqst_pkg::SNR_W-1:0]      snr_average;
  logic [lqst_pkg::Q_W-1:0]               ber_average;
  logic [lqst_pkg::Q_W-1:0]               frame_error_ratio;
  logic [lqst_pkg::Q_W-1:0]               quality_score;

  modport source (output valid, snr_average, ber_average, frame_error_ratio, quality_score,
                  input ready);
  modport sink   (input valid, snr_average, ber_average, frame_error_ratio, quality_score,
                  output ready);
endinterface

interface lqst_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [lqst_pkg::CFG_IDX_W-1:0]         index;
  logic [lqst_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lqst_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqst_mac
// shared signed multiply accumulate unit, one product per cycle while cmd.en is high
// ----------------------------------------------------------------------------
module lqst_mac (
  input  logic                                  clk,
  input  lqst_pkg::mac_cmd_t                    cmd,
  input  logic signed [lqst_pkg::OPND_W-1:0]    op_a,
  input  logic signed [lqst_pkg::OPND_W-1:0]    op_b,
  output logic signed [lqst_pkg::ACC_W-1:0]     acc
);

  logic signed [2*lqst_pkg::OPND_W-1:0] prod;
  logic signed [lqst_pkg::ACC_W-1:0]    acc_r;
  logic signed [lqst_pkg::ACC_W-1:0]    acc_nxt;

  assign prod    = op_a * op_b;
  assign acc_nxt = (cmd.clr ? lqst_pkg::ROUND_HALF : acc_r) + lqst_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== rtl/lqst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqst_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
// quotient = floor((hi * 2^16 + lo) / dvsr) with hi below twice dvsr,
// so the quotient fits seventeen bits
module lqst_div #(
  parameter int DW = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 hi,
  input  logic [lqst_pkg::FRAC_W-1:0]   lo,
  input  logic [DW-1:0]                 dvsr,
  output logic                          done,
  output logic [lqst_pkg::Q_W-1:0]      quot
);

  localparam int CNT_W = $clog2(lqst_pkg::Q_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(lqst_pkg::Q_W - 1);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [DW-1:0]                rem_r;
  logic [DW-1:0]                dvsr_r;
  logic [lqst_pkg::FRAC_W-1:0]  lo_r;
  logic [lqst_pkg::Q_W-1:0]     q_r;
  logic [DW:0]                  trial;
  logic                         ge;

  // first step takes hi as it stands, later ones shift in the low bits
  assign trial = (cnt_r == '0) ? {1'b0, rem_r} : {rem_r, lo_r[lqst_pkg::FRAC_W-1]};
  assign ge    = trial >= {1'b0, dvsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == LAST) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      rem_r  <= hi;
      dvsr_r <= dvsr;
      lo_r   <= lo;
      q_r    <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= ge ? DW'(trial - {1'b0, dvsr_r}) : DW'(trial);
      q_r   <= {q_r[lqst_pkg::Q_W-2:0], ge};
      if (cnt_r != '0) begin
        lo_r <= {lo_r[lqst_pkg::FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/link_quality_score_tracker_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_quality_score_tracker_unit
// link quality tracker: smoothed snr and ber, frame error ratio, quality score
// ----------------------------------------------------------------------------
// The block takes one event item at a time (samples, snr report, ber report,
// frame ok, frame error, clear) and returns one result item holding the snr
// average, ber average, frame error ratio and quality score after that event.
// A small sequencer drives one shared multiply accumulate unit and one shared
// radix-2 divider. Clear, unused kinds, first reports and sample chunks that do
// not reach the update period go from the execute state straight to the result;
// a smoothed report adds a blend of two products through the shared multiplier;
// a frame event waits on the divider's 17 iterations for the error ratio; a
// sample chunk that reaches the update period adds the snr score division plus
// three weighted products. in_ch.ready is high only while the sequencer is idle;
// the result register lets the next item be taken while a result still waits on
// the output. cfg_ch.ready is always high; configuration must be written only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module link_quality_score_tracker_unit #(
  parameter int COUNTER_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  lqst_in_if.sink        in_ch,
  lqst_out_if.source     out_ch,
  lqst_cfg_if.sink       cfg_ch
);

  // divider width: frame counters, or wide enough for the snr span
  localparam int DW = (COUNTER_BITS > lqst_pkg::SNR_SPAN_W) ? COUNTER_BITS
                                                            : lqst_pkg::SNR_SPAN_W;
  localparam int Q_W   = lqst_pkg::Q_W;
  localparam int SNR_W = lqst_pkg::SNR_W;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_EXEC     = 4'd1;
  localparam logic [3:0] ST_BLEND0   = 4'd2;
  localparam logic [3:0] ST_BLEND1   = 4'd3;
  localparam logic [3:0] ST_BLEND_WB = 4'd4;
  localparam logic [3:0] ST_FER_GO   = 4'd5;
  localparam logic [3:0] ST_FER_WAIT = 4'd6;
  localparam logic [3:0] ST_SC_SNR   = 4'd7;
  localparam logic [3:0] ST_SC_WAIT  = 4'd8;
  localparam logic [3:0] ST_SC_M0    = 4'd9;
  localparam logic [3:0] ST_SC_M1    = 4'd10;
  localparam logic [3:0] ST_SC_M2    = 4'd11;
  localparam logic [3:0] ST_SC_WB    = 4'd12;
  localparam logic [3:0] ST_DONE     = 4'd13;

  // configuration
  logic [Q_W-1:0]                  alpha_r, alpha_nxt;
  logic [lqst_pkg::PERIOD_W-1:0]   period_r, period_nxt;

  // sequencer and latched item
  logic [3:0]                      state_r, state_nxt;
  logic [lqst_pkg::KIND_W-1:0]     kind_r;
  logic [lqst_pkg::SAMPLE_W-1:0]   samples_in_r;
  logic signed [SNR_W-1:0]         snr_in_r;
  logic [Q_W-1:0]                  ber_in_r;
  logic [Q_W-1:0]                  ber_clamped;
  logic                            in_fire;

  // tracker state
  logic signed [SNR_W-1:0]         snr_avg_r, snr_avg_nxt;
  logic [Q_W-1:0]                  ber_avg_r, ber_avg_nxt;
  logic [Q_W-1:0]                  fer_r, fer_nxt;
  logic [Q_W-1:0]                  score_r, score_nxt;
  logic [COUNTER_BITS-1:0]         total_r, total_nxt;
  logic [COUNTER_BITS-1:0]         bad_r, bad_nxt;
  logic [lqst_pkg::ACCUM_W-1:0]    samples_r, samples_nxt;
  logic                            snr_seen_r, snr_seen_nxt;
  logic                            ber_seen_r, ber_seen_nxt;
  logic [Q_W-1:0]                  snr_s_r, snr_s_nxt;

  // result register
  logic                            out_valid_r, out_valid_nxt;
  logic signed [SNR_W-1:0]         out_snr_r;
  logic [Q_W-1:0]                  out_ber_r;
  logic [Q_W-1:0]                  out_fer_r;
  logic [Q_W-1:0]                  out_score_r;
  logic                            out_load;

  // shared units
  lqst_pkg::mac_cmd_t                     mac_cmd;
  logic signed [lqst_pkg::OPND_W-1:0]     mac_a, mac_b;
  logic signed [lqst_pkg::ACC_W-1:0]      mac_acc;
  logic                                   div_start;
  logic [DW-1:0]                          div_hi, div_dvsr;
  logic [lqst_pkg::FRAC_W-1:0]            div_lo;
  logic                                   div_done;
  logic [Q_W-1:0]                         div_quot;

  // score helpers
  logic [lqst_pkg::ACCUM_W:0]      sample_sum;
  logic [lqst_pkg::ACCUM_W-1:0]    sample_sat;
  logic signed [SNR_W:0]           snr_shift;
  logic [Q_W+9:0]                  ber_prod;
  logic [Q_W+3:0]                  fer_prod;
  logic [Q_W-1:0]                  ber_s, fer_s;
  logic                            is_snr;

  lqst_mac u_mac (
    .clk  (clk),
    .cmd  (mac_cmd),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  lqst_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .hi    (div_hi),
    .lo    (div_lo),
    .dvsr  (div_dvsr),
    .done  (div_done),
    .quot  (div_quot)
  );

  // ---------------------------------------------------------------- config
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    alpha_nxt  = alpha_r;
    period_nxt = period_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lqst_pkg::REG_ALPHA: begin
          // alpha above one is held at one
          alpha_nxt = (cfg_ch.data[Q_W-1:0] > lqst_pkg::ONE_Q16) ? lqst_pkg::ONE_Q16
                                                                 : cfg_ch.data[Q_W-1:0];
        end
        lqst_pkg::REG_UPDATE_PERIOD: begin
          period_nxt = cfg_ch.data;
        end
        default: begin
          // unknown register, write dropped
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- input
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && (state_r == ST_IDLE);

  // ber report above one is taken as one
  assign ber_clamped = (in_ch.ber_report > lqst_pkg::ONE_Q16) ? lqst_pkg::ONE_Q16
                                                              : in_ch.ber_report;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r       <= in_ch.kind;
      samples_in_r <= in_ch.sample_count;
      snr_in_r     <= in_ch.snr_report;
      ber_in_r     <= ber_clamped;
    end
  end

  // ---------------------------------------------------------------- helpers
  // saturating sample accumulation
  assign sample_sum = {1'b0, samples_r} + (lqst_pkg::ACCUM_W + 1)'(samples_in_r);
  assign sample_sat = sample_sum[lqst_pkg::ACCUM_W] ? '1 : sample_sum[lqst_pkg::ACCUM_W-1:0];

  // snr shifted by ten decibels
  assign snr_shift = (SNR_W + 1)'(snr_avg_r) + lqst_pkg::SNR_OFFSET;

  // ber and fer scores, floored at zero
  assign ber_prod = ber_avg_r * lqst_pkg::BER_GAIN;
  assign fer_prod = fer_r * lqst_pkg::FER_GAIN;
  assign ber_s    = (ber_prod >= (Q_W + 10)'(lqst_pkg::ONE_Q16)) ? '0
                  : Q_W'((Q_W + 10)'(lqst_pkg::ONE_Q16) - ber_prod);
  assign fer_s    = (fer_prod >= (Q_W + 4)'(lqst_pkg::ONE_Q16)) ? '0
                  : Q_W'((Q_W + 4)'(lqst_pkg::ONE_Q16) - fer_prod);

  assign is_snr = (kind_r == lqst_pkg::KIND_SNR);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    snr_avg_nxt   = snr_avg_r;
    ber_avg_nxt   = ber_avg_r;
    fer_nxt       = fer_r;
    score_nxt     = score_r;
    total_nxt     = total_r;
    bad_nxt       = bad_r;
    samples_nxt   = samples_r;
    snr_seen_nxt  = snr_seen_r;
    ber_seen_nxt  = ber_seen_r;
    snr_s_nxt     = snr_s_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    mac_cmd       = '0;
    mac_a         = '0;
    mac_b         = '0;
    div_start     = 1'b0;
    div_hi        = DW'(bad_r);
    div_lo        = '0;
    div_dvsr      = DW'(total_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (kind_r)
          lqst_pkg::KIND_SAMPLES: begin
            // reaching the period recomputes the score and restarts the count
            if (sample_sat >= lqst_pkg::ACCUM_W'(period_r)) begin
              samples_nxt = '0;
              state_nxt   = ST_SC_SNR;
            end else begin
              samples_nxt = sample_sat;
            end
          end
          lqst_pkg::KIND_SNR: begin
            if (snr_seen_r) begin
              state_nxt = ST_BLEND0;
            end else begin
              snr_avg_nxt  = snr_in_r;
              snr_seen_nxt = 1'b1;
            end
          end
          lqst_pkg::KIND_BER: begin
            if (ber_seen_r) begin
              state_nxt = ST_BLEND0;
            end else begin
              ber_avg_nxt  = ber_in_r;
              ber_seen_nxt = 1'b1;
            end
          end
          lqst_pkg::KIND_FRAME_OK, lqst_pkg::KIND_FRAME_ERR: begin
            // saturating frame counters
            if (!(&total_r)) begin
              total_nxt = total_r + 1'b1;
            end
            if (kind_r == lqst_pkg::KIND_FRAME_ERR && !(&bad_r)) begin
              bad_nxt = bad_r + 1'b1;
            end
            state_nxt = ST_FER_GO;
          end
          lqst_pkg::KIND_CLEAR: begin
            // sample count is kept across a clear
            snr_avg_nxt  = '0;
            ber_avg_nxt  = '0;
            fer_nxt      = '0;
            score_nxt    = lqst_pkg::SCORE_RESET;
            total_nxt    = '0;
            bad_nxt      = '0;
            snr_seen_nxt = 1'b0;
            ber_seen_nxt = 1'b0;
          end
          default: begin
            // unused kinds leave the state alone
          end
        endcase
      end

      // avg' = alpha * x + (1 - alpha) * avg, rounded half up
      ST_BLEND0: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b1};
        mac_a     = {1'b0, alpha_r};
        mac_b     = is_snr ? lqst_pkg::OPND_W'(snr_in_r) : {1'b0, ber_in_r};
        state_nxt = ST_BLEND1;
      end

      ST_BLEND1: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0};
        mac_a     = {1'b0, lqst_pkg::ONE_Q16 - alpha_r};
        mac_b     = is_snr ? lqst_pkg::OPND_W'(snr_avg_r) : {1'b0, ber_avg_r};
        state_nxt = ST_BLEND_WB;
      end

      ST_BLEND_WB: begin
        if (is_snr) begin
          snr_avg_nxt = mac_acc[lqst_pkg::FRAC_W +: SNR_W];
        end else begin
          ber_avg_nxt = mac_acc[lqst_pkg::FRAC_W +: Q_W];
        end
        state_nxt = ST_DONE;
      end

      // error ratio: bad * 2^16 / total, total is at least one here
      ST_FER_GO: begin
        div_start = 1'b1;
        state_nxt = ST_FER_WAIT;
      end

      ST_FER_WAIT: begin
        if (div_done) begin
          fer_nxt   = div_quot;
          state_nxt = ST_DONE;
        end
      end

      // snr score clamped to zero and one, divided in the shared divider between
      ST_SC_SNR: begin
        div_hi   = DW'(snr_shift[lqst_pkg::SNR_SPAN_W-1:0]);
        div_lo   = lqst_pkg::SNR_ROUND;
        div_dvsr = DW'(lqst_pkg::SNR_SPAN);
        if (snr_shift[SNR_W] || snr_shift == '0) begin
          snr_s_nxt = '0;
          state_nxt = ST_SC_M0;
        end else if (snr_shift >= (SNR_W + 1)'(lqst_pkg::SNR_SPAN)) begin
          snr_s_nxt = lqst_pkg::ONE_Q16;
          state_nxt = ST_SC_M0;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_SC_WAIT;
        end
      end

      ST_SC_WAIT: begin
        div_hi   = DW'(snr_shift[lqst_pkg::SNR_SPAN_W-1:0]);
        div_lo   = lqst_pkg::SNR_ROUND;
        div_dvsr = DW'(lqst_pkg::SNR_SPAN);
        if (div_done) begin
          snr_s_nxt = div_quot;
          state_nxt = ST_SC_M0;
        end
      end

      // weighted sum 0.5, 0.3, 0.2 through the shared multiplier
      ST_SC_M0: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b1};
        mac_a     = {1'b0, snr_s_r};
        mac_b     = lqst_pkg::W_SNR;
        state_nxt = ST_SC_M1;
      end

      ST_SC_M1: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0};
        mac_a     = {1'b0, ber_s};
        mac_b     = lqst_pkg::W_BER;
        state_nxt = ST_SC_M2;
      end

      ST_SC_M2: begin
        mac_cmd   = '{en: 1'b1, clr: 1'b0};
        mac_a     = {1'b0, fer_s};
        mac_b     = lqst_pkg::W_FER;
        state_nxt = ST_SC_WB;
      end

      ST_SC_WB: begin
        score_nxt = mac_acc[lqst_pkg::FRAC_W +: Q_W];
        state_nxt = ST_DONE;
      end

      // hand the result over once the output register is free
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      alpha_r     <= lqst_pkg::ALPHA_RESET;
      period_r    <= lqst_pkg::PERIOD_RESET;
      snr_avg_r   <= '0;
      ber_avg_r   <= '0;
      fer_r       <= '0;
      score_r     <= lqst_pkg::SCORE_RESET;
      total_r     <= '0;
      bad_r       <= '0;
      samples_r   <= '0;
      snr_seen_r  <= 1'b0;
      ber_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alpha_r     <= alpha_nxt;
      period_r    <= period_nxt;
      snr_avg_r   <= snr_avg_nxt;
      ber_avg_r   <= ber_avg_nxt;
      fer_r       <= fer_nxt;
      score_r     <= score_nxt;
      total_r     <= total_nxt;
      bad_r       <= bad_nxt;
      samples_r   <= samples_nxt;
      snr_seen_r  <= snr_seen_nxt;
      ber_seen_r  <= ber_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snr_s_r <= snr_s_nxt;
    if (out_load) begin
      out_snr_r   <= snr_avg_r;
      out_ber_r   <= ber_avg_r;
      out_fer_r   <= fer_r;
      out_score_r <= score_r;
    end
  end

  // ---------------------------------------------------------------- output
  assign out_ch.valid             = out_valid_r;
  assign out_ch.snr_average       = out_snr_r;
  assign out_ch.ber_average       = out_ber_r;
  assign out_ch.frame_error_ratio = out_fer_r;
  assign out_ch.quality_score     = out_score_r;

endmodule
